### rtl/pfla_pkg.sv
// ----------------------------------------------------------------------------
// Page allocator package
// Shared constants, codes and the command/status bundles that pass between
// the allocator controller and its datapath.
// ----------------------------------------------------------------------------
package pfla_pkg;

    localparam int ADDR_W     = 56;
    localparam int PAGE_SHIFT = 12;
    localparam int PN_W       = ADDR_W - PAGE_SHIFT;

    typedef enum logic [1:0] {
        KIND_BUILD = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_FREE  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_IGNORED = 2'd2,
        ST_DROPPED = 2'd3
    } status_t;

    typedef struct packed {
        logic    capture;
        logic    build_a;
        logic    build_b;
        logic    build_c;
        logic    build_push;
        logic    topup_rd;
        logic    topup_wr;
        logic    alloc_rd;
        logic    alloc_grant;
        logic    drain_rd;
        logic    drain_wr;
        logic    free_push;
        logic    set_status;
        status_t status_code;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  addr_bad;
        logic  fill_zero;
        logic  fill_full;
        logic  gcount_zero;
        logic  gcount_full;
        logic  build_done;
        logic  out_free;
    } stat_t;

endpackage

### rtl/pfla_dpath.sv
// ----------------------------------------------------------------------------
// Page allocator datapath
// Holds the global free stack memory, the cache stack, their counts, the
// build cursor and the output word register. Acts on controller commands and out_ready.
// ----------------------------------------------------------------------------
module pfla_dpath #(
    parameter int MAX_PAGES   = 32768,
    parameter int CACHE_DEPTH = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pfla_pkg::cmd_t              cmd,
    output pfla_pkg::stat_t             stat,
    input  logic [1:0]                  in_kind,
    input  logic [pfla_pkg::ADDR_W-1:0] in_addr,
    input  logic [pfla_pkg::ADDR_W-1:0] region_start,
    input  logic [pfla_pkg::ADDR_W-1:0] region_top,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [pfla_pkg::ADDR_W-1:0] out_addr,
    output logic [1:0]                  out_status
);

    localparam int GCNT_W  = $clog2(MAX_PAGES + 1);
    localparam int GIDX_W  = $clog2(MAX_PAGES);
    localparam int CFILL_W = $clog2(CACHE_DEPTH + 1);
    localparam int CIDX_W  = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int AW      = pfla_pkg::ADDR_W;
    localparam int PW      = pfla_pkg::PN_W;
    localparam int SH      = pfla_pkg::PAGE_SHIFT;

    logic [PW-1:0] gmem [MAX_PAGES];
    logic [PW-1:0] cmem [CACHE_DEPTH];

    pfla_pkg::kind_t   kind_reg;
    pfla_pkg::status_t status_reg;
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     granted_reg;
    logic [GCNT_W-1:0] gcount_reg;
    logic [CFILL_W-1:0] fill_reg;
    logic [PW:0]       first_reg;
    logic              nonempty_reg;
    logic [PW-1:0]     span_reg;
    logic [PW-1:0]     pn_reg;
    logic [GCNT_W-1:0] rem_reg;
    logic [PW-1:0]     g_rdata_reg;
    logic [PW-1:0]     c_rdata_reg;
    logic              out_valid_reg;
    logic [AW-1:0]     out_addr_reg;
    pfla_pkg::status_t out_status_reg;

    logic [GCNT_W-1:0]  gcount_dec;
    logic [CFILL_W-1:0] fill_dec;
    logic [GIDX_W-1:0]  g_wr_idx;
    logic [GIDX_W-1:0]  g_rd_idx;
    logic [CIDX_W-1:0]  c_wr_idx;
    logic [CIDX_W-1:0]  c_rd_idx;
    logic [AW:0]        start_up;
    logic [PW-1:0]      bound;
    logic               gfull;

    assign gcount_dec = gcount_reg - GCNT_W'(1);
    assign fill_dec   = fill_reg - CFILL_W'(1);
    assign g_wr_idx   = gcount_reg[GIDX_W-1:0];
    assign g_rd_idx   = gcount_dec[GIDX_W-1:0];
    assign c_wr_idx   = CIDX_W'(fill_reg);
    assign c_rd_idx   = CIDX_W'(fill_dec);
    assign start_up   = {1'b0, region_start} + (AW+1)'((1 << SH) - 1);
    assign bound      = region_top[AW-1:SH];
    assign gfull      = (gcount_reg == GCNT_W'(MAX_PAGES));

    always_comb
    begin
        stat.kind        = kind_reg;
        stat.addr_bad    = (addr_reg == '0) || (addr_reg[SH-1:0] != '0);
        stat.fill_zero   = (fill_reg == '0);
        stat.fill_full   = (fill_reg == CFILL_W'(CACHE_DEPTH));
        stat.gcount_zero = (gcount_reg == '0);
        stat.gcount_full = gfull;
        stat.build_done  = (rem_reg == '0);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    // Global stack memory: one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.build_push)
        begin
            gmem[g_wr_idx] <= pn_reg;
        end
        else if (cmd.drain_wr && !gfull)
        begin
            gmem[g_wr_idx] <= c_rdata_reg;
        end
        if (cmd.topup_rd)
        begin
            g_rdata_reg <= gmem[g_rd_idx];
        end
    end

    // Cache stack memory: pushes write at the fill level, pops read just below it.
    always_ff @(posedge clk)
    begin
        if (cmd.topup_wr)
        begin
            cmem[c_wr_idx] <= g_rdata_reg;
        end
        else if (cmd.free_push)
        begin
            cmem[c_wr_idx] <= addr_reg[AW-1:SH];
        end
        if (cmd.alloc_rd || cmd.drain_rd)
        begin
            c_rdata_reg <= cmem[c_rd_idx];
        end
    end

    // Item payload and build cursor.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg    <= pfla_pkg::kind_t'(in_kind);
            addr_reg    <= in_addr;
            granted_reg <= '0;
            status_reg  <= pfla_pkg::ST_OK;
        end
        else
        begin
            if (cmd.set_status)
            begin
                status_reg <= cmd.status_code;
            end
            else if (cmd.build_c && nonempty_reg && (span_reg > PW'(MAX_PAGES)))
            begin
                status_reg <= pfla_pkg::ST_DROPPED;
            end
            else if (cmd.drain_wr && gfull)
            begin
                status_reg <= pfla_pkg::ST_DROPPED;
            end
            if (cmd.alloc_grant)
            begin
                granted_reg <= {c_rdata_reg, SH'(0)};
            end
        end
        if (cmd.build_a)
        begin
            first_reg <= start_up[AW:SH];
        end
        if (cmd.build_b)
        begin
            nonempty_reg <= (first_reg < {1'b0, bound});
            span_reg     <= bound - first_reg[PW-1:0];
            pn_reg       <= first_reg[PW-1:0];
        end
        else if (cmd.build_push)
        begin
            pn_reg <= pn_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gcount_reg    <= '0;
            fill_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.build_a)
            begin
                gcount_reg <= '0;
            end
            else if (cmd.build_push || (cmd.drain_wr && !gfull))
            begin
                gcount_reg <= gcount_reg + GCNT_W'(1);
            end
            else if (cmd.topup_rd)
            begin
                gcount_reg <= gcount_dec;
            end

            if (cmd.topup_wr || cmd.free_push)
            begin
                fill_reg <= fill_reg + CFILL_W'(1);
            end
            else if (cmd.alloc_rd || cmd.drain_rd)
            begin
                fill_reg <= fill_dec;
            end

            if (cmd.build_c)
            begin
                if (!nonempty_reg)
                begin
                    rem_reg <= '0;
                end
                else if (span_reg > PW'(MAX_PAGES))
                begin
                    rem_reg <= GCNT_W'(MAX_PAGES);
                end
                else
                begin
                    rem_reg <= span_reg[GCNT_W-1:0];
                end
            end
            else if (cmd.build_push)
            begin
                rem_reg <= rem_reg - GCNT_W'(1);
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_addr_reg   <= granted_reg;
            out_status_reg <= status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_addr   = out_addr_reg;
    assign out_status = out_status_reg;

endmodule

### rtl/pfla_ctrl.sv
// ----------------------------------------------------------------------------
// Page allocator controller
// Sequences build, allocate and free requests as steps on the datapath,
// including the cache refill and flush loops.
// ----------------------------------------------------------------------------
module pfla_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  pfla_pkg::stat_t stat,
    output pfla_pkg::cmd_t  cmd
);

    typedef enum logic [16:0] {
        S_IDLE        = 17'h00001,
        S_DISPATCH    = 17'h00002,
        S_BUILD_A     = 17'h00004,
        S_BUILD_B     = 17'h00008,
        S_BUILD_C     = 17'h00010,
        S_BUILD_PUSH  = 17'h00020,
        S_TOPUP_RD    = 17'h00040,
        S_TOPUP_WR    = 17'h00080,
        S_ALLOC_CHK   = 17'h00100,
        S_ALLOC_POST  = 17'h00200,
        S_ALLOC_RD    = 17'h00400,
        S_ALLOC_GRANT = 17'h00800,
        S_FREE_CHK    = 17'h01000,
        S_DRAIN_RD    = 17'h02000,
        S_DRAIN_WR    = 17'h04000,
        S_FREE_PUSH   = 17'h08000,
        S_DONE        = 17'h10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.status_code = pfla_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.kind)
                    pfla_pkg::KIND_BUILD: state_next = S_BUILD_A;
                    pfla_pkg::KIND_ALLOC: state_next = S_ALLOC_CHK;
                    pfla_pkg::KIND_FREE:  state_next = S_FREE_CHK;
                    default:
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = pfla_pkg::ST_IGNORED;
                        state_next      = S_DONE;
                    end
                endcase
            end
            S_BUILD_A:
            begin
                cmd.build_a = 1'b1;
                state_next  = S_BUILD_B;
            end
            S_BUILD_B:
            begin
                cmd.build_b = 1'b1;
                state_next  = S_BUILD_C;
            end
            S_BUILD_C:
            begin
                cmd.build_c = 1'b1;
                state_next  = S_BUILD_PUSH;
            end
            S_BUILD_PUSH:
            begin
                if (stat.build_done)
                begin
                    state_next = S_TOPUP_RD;
                end
                else
                begin
                    cmd.build_push = 1'b1;
                end
            end
            S_TOPUP_RD:
            begin
                if (stat.fill_full || stat.gcount_zero)
                begin
                    // The refill serves both a build and an empty-cache allocate.
                    if (stat.kind == pfla_pkg::KIND_ALLOC)
                    begin
                        state_next = S_ALLOC_POST;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.topup_rd = 1'b1;
                    state_next   = S_TOPUP_WR;
                end
            end
            S_TOPUP_WR:
            begin
                cmd.topup_wr = 1'b1;
                state_next   = S_TOPUP_RD;
            end
            S_ALLOC_CHK:
            begin
                state_next = stat.fill_zero ? S_TOPUP_RD : S_ALLOC_RD;
            end
            S_ALLOC_POST:
            begin
                if (stat.fill_zero)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = pfla_pkg::ST_OOM;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_ALLOC_RD;
                end
            end
            S_ALLOC_RD:
            begin
                cmd.alloc_rd = 1'b1;
                state_next   = S_ALLOC_GRANT;
            end
            S_ALLOC_GRANT:
            begin
                cmd.alloc_grant = 1'b1;
                state_next      = S_DONE;
            end
            S_FREE_CHK:
            begin
                if (stat.addr_bad)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = pfla_pkg::ST_IGNORED;
                    state_next      = S_DONE;
                end
                else if (stat.fill_full)
                begin
                    state_next = S_DRAIN_RD;
                end
                else
                begin
                    state_next = S_FREE_PUSH;
                end
            end
            S_DRAIN_RD:
            begin
                if (stat.fill_zero)
                begin
                    state_next = S_FREE_PUSH;
                end
                else
                begin
                    cmd.drain_rd = 1'b1;
                    state_next   = S_DRAIN_WR;
                end
            end
            S_DRAIN_WR:
            begin
                cmd.drain_wr = 1'b1;
                state_next   = S_DRAIN_RD;
            end
            S_FREE_PUSH:
            begin
                cmd.free_push = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/page_free_list_allocator_with_cache_core.sv
// ----------------------------------------------------------------------------
// Page free list allocator with cache
// Channel  Direction  Contents
// s_*      in         tuser = kind (2 b), tdata = page_addr (56 b)
// m_*      out        tuser = status (2 b), tdata = granted_addr (56 b)
// APB      in/out     region_start at 0x0, region_top at 0x8 (64-bit data)
//
// One request at a time, accepted only in the idle state. An allocate pops the
// cache, refilling it from the global stack first when it is empty (out of memory
// if it stays empty); a free pushes onto the cache, flushing a full cache into the
// stack first; a build fills the stack with the region's pages, then refills the
// cache. Reset needs no clearing pass; counts track the stacks.
// A waiting result does not block the next accept, only the load of its result.
// ----------------------------------------------------------------------------
module page_free_list_allocator_with_cache_core #(
    parameter int MAX_PAGES   = 32768,
    parameter int CACHE_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [55:0] page_addr
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [55:0] granted_addr
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int AW = pfla_pkg::ADDR_W;

    pfla_pkg::cmd_t  cmd;
    pfla_pkg::stat_t stat;
    logic [AW-1:0]   region_start_reg;
    logic [AW-1:0]   region_top_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= '0;
            region_top_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[3])
            begin
                region_top_reg <= pwdata[AW-1:0];
            end
            else
            begin
                region_start_reg <= pwdata[AW-1:0];
            end
        end
    end

    assign prdata = paddr[3] ? {8'b0, region_top_reg} : {8'b0, region_start_reg};

    pfla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfla_dpath #(
        .MAX_PAGES   (MAX_PAGES),
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_kind      (s_tuser),
        .in_addr      (s_tdata),
        .region_start (region_start_reg),
        .region_top   (region_top_reg),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_addr     (m_tdata),
        .out_status   (m_tuser)
    );

`ifndef NO_ASSERTIONS
    // After an accept the controller is busy until the word is produced.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice without a result in between");

    // A new result word only appears after a busy cycle.
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result word appeared while the controller was idle");

    a_cache_level: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.fill_zero && stat.fill_full))
        else $error("cache fill level is both empty and full");

    // A result is only loaded when the output register can take it.
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("result loaded over an untaken word");
`endif

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page allocator testbench
// Feeds build, allocate and free requests through the stream input under
// random bursts and output stalls, keeps its own copy of the free stack and
// page cache, and checks every result word in order. The region registers
// are reprogrammed over APB between phases and read back after each write.
// ----------------------------------------------------------------------------
module tb;

    localparam int ADDR_W        = pfla_pkg::ADDR_W;
    localparam int PN_W          = pfla_pkg::PN_W;
    localparam int PAGE_SHIFT    = pfla_pkg::PAGE_SHIFT;
    localparam int POOL_PAGES    = 32768;
    localparam int CACHE_SLOTS   = 8;
    localparam int PAGE_BYTES    = 4096;
    localparam int PHASES        = 8;
    localparam int PHASE_REQS    = 125;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 120000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 300;

    typedef enum logic [3:0] {
        REG_REGION_START = 4'h0,
        REG_REGION_TOP   = 4'h8
    } reg_addr_t;

    typedef struct {
        pfla_pkg::kind_t   kind;
        logic [ADDR_W-1:0] addr;
    } request_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        pfla_pkg::status_t status;
    } grant_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;     // [55:0] page_addr
    logic [1:0]  s_tuser  = '0;     // [1:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;           // [55:0] granted_addr
    logic [1:0]  m_tuser;           // [1:0] status
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [63:0] pwdata   = '0;
    logic [63:0] prdata;
    logic        pready;

    // Allocator state as the checker tracks it.
    logic [PN_W-1:0]   free_pool [POOL_PAGES];
    int unsigned       pool_depth = 0;
    logic [PN_W-1:0]   cached_pages [CACHE_SLOTS];
    int unsigned       cache_fill = 0;
    logic [ADDR_W-1:0] region_start = '0;
    logic [ADDR_W-1:0] region_top   = '0;

    request_t    pending_reqs[$];
    grant_t      expected_grants[$];
    bit          req_taken    = 1'b0;
    int unsigned burst_left   = 0;
    int unsigned gap_left     = 0;
    int unsigned rx_cycle     = 0;
    int unsigned hold_left    = 0;
    bit          held_once    = 1'b0;
    int unsigned results_seen = 0;
    int unsigned errors       = 0;
    int unsigned settings     = 0;
    int unsigned kind_hits [4]   = '{default: 0};
    int unsigned status_hits [4] = '{default: 0};

    page_free_list_allocator_with_cache_core #(
        .MAX_PAGES   (POOL_PAGES),
        .CACHE_DEPTH (CACHE_SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void top_up_model_cache();
        while (cache_fill < CACHE_SLOTS && pool_depth > 0)
        begin
            pool_depth--;
            cached_pages[cache_fill] = free_pool[pool_depth];
            cache_fill++;
        end
    endfunction

    function automatic grant_t serve_request(pfla_pkg::kind_t kind,
                                             logic [ADDR_W-1:0] addr);
        grant_t      g;
        logic [63:0] first_pn;
        logic [63:0] bound_pn;
        logic [63:0] span;
        logic [63:0] k;
        logic        lost;
        g.addr   = '0;
        g.status = pfla_pkg::ST_OK;
        lost     = 1'b0;
        case (kind)
            pfla_pkg::KIND_BUILD:
            begin
                first_pn   = (64'(region_start) + 64'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
                bound_pn   = 64'(region_top) >> PAGE_SHIFT;
                pool_depth = 0;
                if (first_pn < bound_pn)
                begin
                    span = bound_pn - first_pn;
                    // Only the lowest pages fit; the rest are dropped.
                    if (span > 64'(POOL_PAGES))
                    begin
                        span     = 64'(POOL_PAGES);
                        g.status = pfla_pkg::ST_DROPPED;
                    end
                    for (k = 0; k < span; k++)
                        free_pool[k] = PN_W'(first_pn + k);
                    pool_depth = 32'(span);
                end
                top_up_model_cache();
            end
            pfla_pkg::KIND_ALLOC:
            begin
                if (cache_fill == 0)
                    top_up_model_cache();
                if (cache_fill == 0)
                    g.status = pfla_pkg::ST_OOM;
                else
                begin
                    cache_fill--;
                    g.addr = {cached_pages[cache_fill], {PAGE_SHIFT{1'b0}}};
                end
            end
            pfla_pkg::KIND_FREE:
            begin
                if (addr == '0 || addr[PAGE_SHIFT-1:0] != '0)
                    g.status = pfla_pkg::ST_IGNORED;
                else
                begin
                    // A full cache is flushed first; entries that find the
                    // stack full are lost, but the freed page still goes in.
                    if (cache_fill >= CACHE_SLOTS)
                    begin
                        while (cache_fill > 0)
                        begin
                            cache_fill--;
                            if (pool_depth >= POOL_PAGES)
                                lost = 1'b1;
                            else
                            begin
                                free_pool[pool_depth] = cached_pages[cache_fill];
                                pool_depth++;
                            end
                        end
                        if (lost)
                            g.status = pfla_pkg::ST_DROPPED;
                    end
                    cached_pages[cache_fill] = addr[ADDR_W-1:PAGE_SHIFT];
                    cache_fill++;
                end
            end
            default:
                g.status = pfla_pkg::ST_IGNORED;
        endcase
        return g;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic [ADDR_W-1:0] rand_page();
        logic [ADDR_W-1:0] a;
        a = rand_addr();
        a[PAGE_SHIFT-1:0] = '0;
        if (a == '0)
            a[PAGE_SHIFT] = 1'b1;
        return a;
    endfunction

    function automatic void queue_request(pfla_pkg::kind_t kind, logic [ADDR_W-1:0] addr);
        request_t r;
        r.kind = kind;
        r.addr = addr;
        pending_reqs.push_back(r);
    endfunction

    // A build followed by a random mix of allocs, frees, rebuilds when enabled and
    // unused-kind items; the frees are mostly of pages in the current region.
    task automatic queue_mixed_requests(int unsigned count, bit rebuilds);
        logic [63:0]       first_pn;
        logic [63:0]       bound_pn;
        logic [63:0]       span;
        logic [ADDR_W-1:0] a;
        int unsigned       pick;
        int unsigned       i;
        first_pn = (64'(region_start) + 64'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
        bound_pn = 64'(region_top) >> PAGE_SHIFT;
        span     = (first_pn < bound_pn) ? bound_pn - first_pn : 64'd0;
        if (span > 64'd64)
            span = 64'd64;
        queue_request(pfla_pkg::KIND_BUILD, rand_addr());
        for (i = 1; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            a    = rand_addr();
            if (pick < 42)
                queue_request(pfla_pkg::KIND_ALLOC, a);
            else if (pick < 70 && span != 0)
                queue_request(pfla_pkg::KIND_FREE,
                    ADDR_W'((first_pn + $urandom_range(0, 32'(span) - 1)) << PAGE_SHIFT));
            else if (pick < 82)
                queue_request(pfla_pkg::KIND_FREE, rand_page());
            else if (pick < 90)
            begin
                if (pick[0])
                    a = '0;
                else if (a[PAGE_SHIFT-1:0] == '0)
                    a[0] = 1'b1;
                queue_request(pfla_pkg::KIND_FREE, a);
            end
            else if (pick < 95 && rebuilds)
                queue_request(pfla_pkg::KIND_BUILD, a);
            else
                queue_request(pfla_pkg::KIND_NONE, a);
        end
    endtask

    // Write a register, then read it back in the following transfer.
    task automatic apb_write(reg_addr_t where, logic [ADDR_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= where;
        pwdata  <= 64'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[ADDR_W-1:0] !== value)
        begin
            errors++;
            $display("%0t: register %s read back: expected %h, got %h",
                     $time, where.name(), value, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_region(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
        apb_write(REG_REGION_START, lo);
        region_start = lo;
        apb_write(REG_REGION_TOP, hi);
        region_top = hi;
        settings++;
    endtask

    // Every item yields one word, so the block is idle once all are back.
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_reqs.size() != 0 || s_tvalid || expected_grants.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
    begin : drive_requests
        request_t next_req;
        if (rst_n && (!s_tvalid || req_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                next_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_req.kind;
                s_tdata  <= next_req.addr;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!held_once && results_seen >= HOLD_AFTER)
            begin
                // One long hold-off so the block backs up into its input.
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_cycle[8:7])
                    2'd0: m_tready <= 1'b1;
                    2'd1: m_tready <= 1'($urandom_range(0, 1));
                    2'd2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (rx_cycle[2:0] != 3'd0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_grants
        grant_t g;
        if (rst_n)
        begin
            req_taken = s_tvalid && s_tready;
            if (req_taken)
            begin
                kind_hits[s_tuser]++;
                expected_grants.push_back(
                    serve_request(pfla_pkg::kind_t'(s_tuser), s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_grants.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word: granted_addr %h, status %0d",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    g = expected_grants.pop_front();
                    status_hits[g.status]++;
                    if (m_tdata !== g.addr)
                    begin
                        errors++;
                        $display("%0t: granted_addr expected %h, got %h",
                                 $time, g.addr, m_tdata);
                    end
                    if (m_tuser !== g.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, g.status, m_tuser);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        int unsigned       p;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Straight out of reset: empty region, nothing to hand out.
        queue_request(pfla_pkg::KIND_ALLOC, '0);
        queue_request(pfla_pkg::KIND_BUILD, '0);
        queue_request(pfla_pkg::KIND_FREE, '0);
        queue_request(pfla_pkg::KIND_FREE, 56'h00_0000_0000_1001);
        queue_request(pfla_pkg::KIND_NONE, '1);
        wait_idle();

        // Ten pages from a misaligned start; the ninth alloc has to refill
        // and the eighth good free flushes a full cache.
        write_region(56'h1234, 56'hC005);
        queue_request(pfla_pkg::KIND_BUILD, '0);
        repeat (9) queue_request(pfla_pkg::KIND_ALLOC, '0);
        queue_request(pfla_pkg::KIND_FREE, 56'hFF_FFFF_FFFF_F000);
        queue_request(pfla_pkg::KIND_FREE, 56'h3000);
        queue_request(pfla_pkg::KIND_FREE, 56'h3000);
        queue_request(pfla_pkg::KIND_FREE, 56'h3800);
        for (p = 4; p <= 8; p++)
            queue_request(pfla_pkg::KIND_FREE, ADDR_W'(p) << PAGE_SHIFT);
        repeat (3) queue_request(pfla_pkg::KIND_ALLOC, '1);
        wait_idle();

        // Whole address space: the build is clipped while the cache keeps its
        // pages, so the next flush finds the stack full.
        write_region('0, '1);
        queue_request(pfla_pkg::KIND_BUILD, '0);
        repeat (9) queue_request(pfla_pkg::KIND_FREE, rand_page());
        repeat (3) queue_request(pfla_pkg::KIND_ALLOC, '0);
        wait_idle();

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    lo = '0;
                    hi = ADDR_W'(20 * PAGE_BYTES);
                end
                2:
                begin
                    lo = '1;
                    hi = '1;
                end
                4:
                begin
                    lo = 56'hFF_FFFF_F000_0000 | ADDR_W'($urandom_range(0, 24'hFF_FFFF));
                    hi = '1;
                end
                default:
                begin
                    lo = rand_addr();
                    hi = ADDR_W'(64'(lo) + 64'($urandom_range(0, 48)) * PAGE_BYTES
                                 + 64'($urandom_range(0, PAGE_BYTES - 1)));
                end
            endcase
            write_region(lo, hi);
            queue_mixed_requests(PHASE_REQS, p != 4);
            wait_idle();
        end

        $write("Ran %0d requests over %0d region settings: ",
               kind_hits[0] + kind_hits[1] + kind_hits[2] + kind_hits[3], settings);
        $display("%0d builds, %0d allocs, %0d frees, %0d of the unused kind.",
                 kind_hits[pfla_pkg::KIND_BUILD], kind_hits[pfla_pkg::KIND_ALLOC],
                 kind_hits[pfla_pkg::KIND_FREE], kind_hits[pfla_pkg::KIND_NONE]);
        $display("Words checked: %0d ok, %0d out of memory, %0d ignored, %0d dropped.",
                 status_hits[pfla_pkg::ST_OK], status_hits[pfla_pkg::ST_OOM],
                 status_hits[pfla_pkg::ST_IGNORED], status_hits[pfla_pkg::ST_DROPPED]);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
